>>> rtl/irr_pkg.sv
// Shared types and constants of the interval range remap block.
package irr_pkg;

	// Table size and derived widths.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int VAL_W       = 40;

	// Command codes of an input word.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_XLATE = 2'd2;

	// Kind codes of a result word.
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FULL  = 2'd1;
	localparam logic [1:0] KIND_PIECE = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	typedef logic [VAL_W-1:0] val_t;

	// One table entry; the destination is kept as an offset from the source start.
	typedef struct packed {
		val_t src_start;
		val_t src_end;
		val_t delta;
	} entry_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BELOW,
		ST_INSIDE,
		ST_TAIL
	} state_t;

	// Which value goes into the output register.
	typedef enum logic [1:0] {
		SEL_RESP,
		SEL_BELOW,
		SEL_INSIDE,
		SEL_TAIL
	} sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       advance;
		logic       emit;
		sel_t       sel;
		logic [1:0] resp_kind;
		logic       last;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic below_hit;
		logic inside_hit;
		logic done;
		logic last_entry;
		logic table_full;
		logic table_empty;
		logic query_empty;
	} dp_stat_t;

endpackage

>>> rtl/irr_in_if.sv
// Input channel: one command word per handshake.
interface irr_in_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              cmd;
	logic [irr_pkg::VAL_W-1:0] value_start;
	logic [irr_pkg::VAL_W-1:0] value_end;
	logic [irr_pkg::VAL_W-1:0] dest_start;

	modport source (output valid, cmd, value_start, value_end, dest_start, input ready);
	modport sink (input valid, cmd, value_start, value_end, dest_start, output ready);
endinterface

>>> rtl/irr_out_if.sv
// Output channel: one result word per handshake.
interface irr_out_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              kind;
	logic [irr_pkg::VAL_W-1:0] piece_start;
	logic [irr_pkg::VAL_W-1:0] piece_end;
	logic                    was_mapped;
	logic                    last;

	modport source (output valid, kind, piece_start, piece_end, was_mapped, last, input ready);
	modport sink (input valid, kind, piece_start, piece_end, was_mapped, last, output ready);
endinterface

>>> rtl/irr_ctrl.sv
// Controller: sequences the table walk and decides which word to emit.
module irr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_cmd,
	output logic              in_ready,
	input  irr_pkg::dp_stat_t stat,
	output irr_pkg::ctrl_cmd_t cmd
);

	irr_pkg::state_t state_q;
	irr_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_next    = state_q;
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.advance   = 1'b0;
		cmd.emit      = 1'b0;
		cmd.sel       = irr_pkg::SEL_RESP;
		cmd.resp_kind = irr_pkg::KIND_ACK;
		cmd.last      = 1'b1;
		unique case (state_q)
			irr_pkg::ST_IDLE: begin
				in_ready   = stat.out_free;
				cmd.accept = in_valid && stat.out_free;
				if (cmd.accept) begin
					if (in_cmd == irr_pkg::CMD_XLATE && !stat.query_empty) begin
						state_next = stat.table_empty ? irr_pkg::ST_TAIL : irr_pkg::ST_BELOW;
					end else begin
						// Single-word answers leave straight from the accept cycle.
						cmd.emit = 1'b1;
						unique case (in_cmd)
							irr_pkg::CMD_LOAD: begin
								cmd.resp_kind = stat.table_full ? irr_pkg::KIND_FULL
									: irr_pkg::KIND_ACK;
							end
							irr_pkg::CMD_XLATE: begin
								cmd.resp_kind = irr_pkg::KIND_EMPTY;
							end
							default: begin
								cmd.resp_kind = irr_pkg::KIND_ACK;
							end
						endcase
					end
				end
			end
			irr_pkg::ST_BELOW: begin
				// The part of the interval below the entry's source start.
				cmd.sel  = irr_pkg::SEL_BELOW;
				cmd.last = stat.done && !stat.inside_hit;
				if (!stat.below_hit) begin
					state_next = irr_pkg::ST_INSIDE;
				end else if (stat.out_free) begin
					cmd.emit   = 1'b1;
					state_next = cmd.last ? irr_pkg::ST_IDLE : irr_pkg::ST_INSIDE;
				end
			end
			irr_pkg::ST_INSIDE: begin
				// The part inside the source interval, then move on or stop.
				cmd.sel  = irr_pkg::SEL_INSIDE;
				cmd.last = stat.done;
				if (!stat.inside_hit || stat.out_free) begin
					cmd.emit = stat.inside_hit;
					if (stat.done) begin
						state_next = irr_pkg::ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_next  = stat.last_entry ? irr_pkg::ST_TAIL : irr_pkg::ST_BELOW;
					end
				end
			end
			irr_pkg::ST_TAIL: begin
				// Whatever remains after the last entry passes through.
				cmd.sel = irr_pkg::SEL_TAIL;
				if (stat.out_free) begin
					cmd.emit   = 1'b1;
					state_next = irr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = irr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/irr_dp.sv
// Datapath: entry table, walk registers, piece arithmetic and output register.
module irr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          in_cmd,
	input  irr_pkg::val_t       in_value_start,
	input  irr_pkg::val_t       in_value_end,
	input  irr_pkg::val_t       in_dest_start,
	input  irr_pkg::ctrl_cmd_t  cmd,
	output irr_pkg::dp_stat_t   stat,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [1:0]          out_kind,
	output irr_pkg::val_t       out_piece_start,
	output irr_pkg::val_t       out_piece_end,
	output logic                out_was_mapped,
	output logic                out_last
);

	irr_pkg::entry_t mem [irr_pkg::MAX_ENTRIES];
	irr_pkg::entry_t rd_q;

	logic [irr_pkg::CNT_W-1:0] count_q;
	logic [irr_pkg::CNT_W-1:0] idx_q;
	logic [irr_pkg::CNT_W-1:0] idx_inc;
	logic [irr_pkg::CNT_W-1:0] rd_addr;
	irr_pkg::val_t             s_q;
	irr_pkg::val_t             e_q;

	logic                      out_valid_q;
	logic [1:0]                kind_q;
	irr_pkg::val_t             start_q;
	irr_pkg::val_t             end_q;
	logic                      mapped_q;
	logic                      last_q;

	irr_pkg::val_t below_end;
	irr_pkg::val_t in_start;
	irr_pkg::val_t in_end;
	irr_pkg::val_t rest_start;
	logic          load_ok;

	// Piece boundaries of the current entry against the remaining interval.
	always_comb begin
		below_end  = (e_q < rd_q.src_start) ? e_q : rd_q.src_start;
		in_start   = (s_q > rd_q.src_start) ? s_q : rd_q.src_start;
		in_end     = (e_q < rd_q.src_end) ? e_q : rd_q.src_end;
		rest_start = (s_q > rd_q.src_end) ? s_q : rd_q.src_end;
		idx_inc    = idx_q + 1'b1;
		load_ok    = cmd.accept && in_cmd == irr_pkg::CMD_LOAD && !stat.table_full;
	end

	// Status towards the controller.
	always_comb begin
		stat.out_free    = !out_valid_q || out_ready;
		stat.below_hit   = s_q < rd_q.src_start;
		stat.inside_hit  = in_start < in_end;
		stat.done        = rest_start >= e_q;
		stat.last_entry  = idx_inc >= count_q;
		stat.table_full  = count_q == irr_pkg::CNT_W'(irr_pkg::MAX_ENTRIES);
		stat.table_empty = count_q == '0;
		stat.query_empty = in_value_start >= in_value_end;
	end

	// Read address: first entry on a new query, next entry when the walk advances.
	always_comb begin
		if (cmd.accept) begin
			rd_addr = '0;
		end else if (cmd.advance) begin
			rd_addr = idx_inc;
		end else begin
			rd_addr = idx_q;
		end
	end

	// Entry table, written in load order and read with a registered port.
	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem[count_q[irr_pkg::IDX_W-1:0]] <= '{
				src_start: in_value_start,
				src_end:   in_value_end,
				delta:     in_dest_start - in_value_start
			};
		end
		rd_q <= mem[rd_addr[irr_pkg::IDX_W-1:0]];
	end

	// Fill count of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept && in_cmd == irr_pkg::CMD_CLEAR) begin
			count_q <= '0;
		end else if (load_ok) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Walk position and remaining interval.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q <= '0;
			s_q   <= in_value_start;
			e_q   <= in_value_end;
		end else if (cmd.advance) begin
			idx_q <= idx_inc;
			s_q   <= rest_start;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q <= cmd.last;
			unique case (cmd.sel)
				irr_pkg::SEL_RESP: begin
					kind_q   <= cmd.resp_kind;
					start_q  <= '0;
					end_q    <= '0;
					mapped_q <= 1'b0;
				end
				irr_pkg::SEL_BELOW: begin
					kind_q   <= irr_pkg::KIND_PIECE;
					start_q  <= s_q;
					end_q    <= below_end;
					mapped_q <= 1'b0;
				end
				irr_pkg::SEL_INSIDE: begin
					kind_q   <= irr_pkg::KIND_PIECE;
					start_q  <= in_start + rd_q.delta;
					end_q    <= in_end + rd_q.delta;
					mapped_q <= 1'b1;
				end
				irr_pkg::SEL_TAIL: begin
					kind_q   <= irr_pkg::KIND_PIECE;
					start_q  <= s_q;
					end_q    <= e_q;
					mapped_q <= 1'b0;
				end
				default: begin
					kind_q   <= irr_pkg::KIND_ACK;
					start_q  <= '0;
					end_q    <= '0;
					mapped_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign out_kind        = kind_q;
	assign out_piece_start = start_q;
	assign out_piece_end   = end_q;
	assign out_was_mapped  = mapped_q;
	assign out_last        = last_q;

endmodule

>>> rtl/interval_range_remap_core.sv
// Channel | Direction | Word
// req     | in        | cmd, value_start, value_end, dest_start
// rsp     | out       | kind, piece_start, piece_end, was_mapped, last
//
// Clear, load and undefined commands answer with a single word.
// A translate walks the table one entry at a time through the single read port: for
// each entry a below state handles the part below it and an inside state the part
// inside it; a tail state passes on what remains after the last entry.
// Reset clears the fill count and the controller; table contents stay
// undefined until loaded. A stalled rsp holds the walk; a new word is taken only
// once the previous one has delivered its last word or is being taken.
module interval_range_remap_core (
	input logic         clk,
	input logic         arst_n,
	irr_in_if.sink      req,
	irr_out_if.source   rsp
);

	irr_pkg::ctrl_cmd_t cmd;
	irr_pkg::dp_stat_t  stat;
	logic               req_ready;

	irr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.in_ready (req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	irr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_cmd          (req.cmd),
		.in_value_start  (req.value_start),
		.in_value_end    (req.value_end),
		.in_dest_start   (req.dest_start),
		.cmd             (cmd),
		.stat            (stat),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_kind        (rsp.kind),
		.out_piece_start (rsp.piece_start),
		.out_piece_end   (rsp.piece_end),
		.out_was_mapped  (rsp.was_mapped),
		.out_last        (rsp.last)
	);

	assign req.ready = req_ready;

	// A word is only taken when the output register has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !rsp.valid || rsp.ready)
		else $error("word accepted while output register blocked");

	// Any command other than translate answers with one final word next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.cmd != irr_pkg::CMD_XLATE |=> rsp.valid && rsp.last)
		else $error("single-word answer missing");

	// Non-piece words always close their command.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind != irr_pkg::KIND_PIECE |-> rsp.last)
		else $error("non-piece word not marked last");

	// Non-piece words carry zero piece fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind != irr_pkg::KIND_PIECE
		|-> rsp.piece_start == '0 && rsp.piece_end == '0 && !rsp.was_mapped)
		else $error("non-piece word with piece fields set");

endmodule

>>> bench/interval_range_remap_core_tb.sv
`timescale 1ns / 100ps

module interval_range_remap_core_tb;
	import irr_pkg::*;

	localparam logic [1:0] CMD_UNDEF    = 2'd3;
	localparam val_t       VMAX         = {VAL_W{1'b1}};
	localparam int         NUM_DIRECTED = 25;
	localparam int         NUM_RANDOM   = 280;
	localparam int         QUIET_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 2 * MAX_ENTRIES + 4;

	// One result word as the block should deliver it.
	typedef struct packed {
		logic [1:0] kind;
		val_t       piece_start;
		val_t       piece_end;
		logic       was_mapped;
		logic       last;
	} remap_word_t;

	// One directed stimulus word; a fixed row carries its single answer by hand.
	typedef struct packed {
		logic [1:0] cmd;
		val_t       vs;
		val_t       ve;
		val_t       ds;
		logic       fixed;
		logic [1:0] kind;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	irr_in_if  req_if ();
	irr_out_if rsp_if ();

	interval_range_remap_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Mirror of the remap table.
	val_t map_src_start [MAX_ENTRIES];
	val_t map_src_end   [MAX_ENTRIES];
	val_t map_dest      [MAX_ENTRIES];
	int   map_fill;

	remap_word_t step_words [$];
	remap_word_t remap_due  [$];
	stim_row_t   directed_rows [NUM_DIRECTED];

	int   mismatches;
	int   words_sent;
	bit   no_idle;
	val_t window_base;

	always #10 clk = ~clk;

	// Queue one predicted word of the current command.
	function automatic void add_word(logic [1:0] kind, val_t s, val_t e, logic mapped);
		remap_word_t w;
		w.kind        = kind;
		w.piece_start = s;
		w.piece_end   = e;
		w.was_mapped  = mapped;
		w.last        = 1'b0;
		step_words.push_back(w);
	endfunction

	// Work out the words caused by one command and update the table mirror.
	function automatic void remap_step(logic [1:0] cmd, val_t vs, val_t ve, val_t ds);
		val_t s, e, ss, se, d, be, is, ie, rs;
		bit   done;
		remap_word_t w;
		step_words.delete();
		case (cmd)
			CMD_CLEAR: begin
				map_fill = 0;
				add_word(KIND_ACK, '0, '0, 1'b0);
			end
			CMD_LOAD: begin
				if (map_fill < MAX_ENTRIES) begin
					map_src_start[map_fill] = vs;
					map_src_end[map_fill]   = ve;
					map_dest[map_fill]      = ds;
					map_fill++;
					add_word(KIND_ACK, '0, '0, 1'b0);
				end else begin
					add_word(KIND_FULL, '0, '0, 1'b0);
				end
			end
			CMD_XLATE: begin
				s    = vs;
				e    = ve;
				done = 0;
				if (s >= e) begin
					add_word(KIND_EMPTY, '0, '0, 1'b0);
				end else begin
					for (int i = 0; i < map_fill && !done; i++) begin
						ss = map_src_start[i];
						se = map_src_end[i];
						d  = map_dest[i];
						be = (e < ss) ? e : ss;
						is = (s > ss) ? s : ss;
						ie = (e < se) ? e : se;
						rs = (s > se) ? s : se;
						if (s < be)
							add_word(KIND_PIECE, s, be, 1'b0);
						if (is < ie)
							add_word(KIND_PIECE, d + (is - ss), d + (ie - ss), 1'b1);
						if (rs >= e)
							done = 1;
						else
							s = rs;
					end
					if (!done && s < e)
						add_word(KIND_PIECE, s, e, 1'b0);
					if (step_words.size() == 0)
						add_word(KIND_EMPTY, '0, '0, 1'b0);
				end
			end
			default: begin
				add_word(KIND_ACK, '0, '0, 1'b0);
			end
		endcase
		w = step_words.pop_back();
		w.last = 1'b1;
		step_words.push_back(w);
	endfunction

	function automatic stim_row_t mk_row(logic [1:0] cmd, val_t vs, val_t ve, val_t ds,
			logic fixed, logic [1:0] kind);
		stim_row_t r;
		r.cmd   = cmd;
		r.vs    = vs;
		r.ve    = ve;
		r.ds    = ds;
		r.fixed = fixed;
		r.kind  = kind;
		return r;
	endfunction

	function automatic val_t rand_wide();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[VAL_W-1:0];
	endfunction

	// Mostly values near the current window, so entries and queries overlap.
	function automatic val_t rand_point();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return VMAX;
			2, 3:    return rand_wide();
			default: return window_base + val_t'($urandom_range(0, 4095));
		endcase
	endfunction

	// Present one word after a random gap and wait until it is taken.
	task automatic send_word(logic [1:0] cmd, val_t vs, val_t ve, val_t ds,
			logic fixed, logic [1:0] kind);
		int          gap;
		remap_word_t w;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.cmd         = cmd;
		req_if.value_start = vs;
		req_if.value_end   = ve;
		req_if.dest_start  = ds;
		req_if.valid       = 1'b1;
		do @(posedge clk); while (!req_if.ready);
		remap_step(cmd, vs, ve, ds);
		if (fixed) begin
			w.kind        = kind;
			w.piece_start = '0;
			w.piece_end   = '0;
			w.was_mapped  = 1'b0;
			w.last        = 1'b1;
			remap_due.push_back(w);
		end else begin
			foreach (step_words[i])
				remap_due.push_back(step_words[i]);
		end
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_entry();
		val_t s, e, d;
		s = rand_point();
		case ($urandom_range(0, 9))
			0:       e = rand_point();
			1:       e = s;
			default: e = s + val_t'($urandom_range(1, 800));
		endcase
		d = ($urandom_range(0, 2) == 0) ? rand_wide() : rand_point();
		send_word(CMD_LOAD, s, e, d, 1'b0, KIND_ACK);
	endtask

	task automatic send_query();
		val_t s, e;
		s = rand_point();
		case ($urandom_range(0, 9))
			0: begin
				s = '0;
				e = VMAX;
			end
			1:       e = rand_point();
			2:       e = s;
			default: e = s + val_t'($urandom_range(1, 3000));
		endcase
		send_word(CMD_XLATE, s, e, rand_wide(), 1'b0, KIND_ACK);
	endtask

	// Result side: stall at random before each word, then take it.
	initial begin
		int stall;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				rsp_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			@(negedge clk);
		end
	end

	// Compare each delivered word with the oldest one still due.
	always @(posedge clk) begin
		remap_word_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (remap_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected word kind=%0d start=%h end=%h mapped=%b last=%b",
						$realtime, rsp_if.kind, rsp_if.piece_start, rsp_if.piece_end,
						rsp_if.was_mapped, rsp_if.last);
			end else begin
				want = remap_due.pop_front();
				if (rsp_if.kind !== want.kind || rsp_if.piece_start !== want.piece_start ||
						rsp_if.piece_end !== want.piece_end ||
						rsp_if.was_mapped !== want.was_mapped || rsp_if.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch kind %0d/%0d start %h/%h end %h/%h ",
							"mapped %b/%b last %b/%b (expected/actual)"}, $realtime,
							want.kind, rsp_if.kind, want.piece_start, rsp_if.piece_start,
							want.piece_end, rsp_if.piece_end, want.was_mapped,
							rsp_if.was_mapped, want.last, rsp_if.last);
				end
			end
		end
	end

	// Watchdog: end the run when no word moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("interval_range_remap_core_tb failed");
		$finish;
	end

	initial begin
		int n_entries;
		int n_queries;
		mismatches         = 0;
		words_sent         = 0;
		no_idle            = 0;
		map_fill           = 0;
		window_base        = '0;
		req_if.valid       = 1'b0;
		req_if.cmd         = CMD_CLEAR;
		req_if.value_start = '0;
		req_if.value_end   = '0;
		req_if.dest_start  = '0;
		arst_n             = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: empty table, empty queries, undefined command, a full
		// table of overlapping, unsorted, empty and wrapping entries.
		directed_rows[0]  = mk_row(CMD_CLEAR, '0, '0, '0, 1'b1, KIND_ACK);
		directed_rows[1]  = mk_row(CMD_XLATE, '0, VMAX, '0, 1'b0, KIND_ACK);
		directed_rows[2]  = mk_row(CMD_XLATE, 40'd5, 40'd5, '0, 1'b1, KIND_EMPTY);
		directed_rows[3]  = mk_row(CMD_XLATE, VMAX, '0, VMAX, 1'b1, KIND_EMPTY);
		directed_rows[4]  = mk_row(CMD_UNDEF, VMAX, VMAX, VMAX, 1'b1, KIND_ACK);
		directed_rows[5]  = mk_row(CMD_LOAD, 40'd100, 40'd200, 40'd1000, 1'b1, KIND_ACK);
		directed_rows[6]  = mk_row(CMD_LOAD, 40'd150, 40'd300, 40'd50, 1'b1, KIND_ACK);
		directed_rows[7]  = mk_row(CMD_LOAD, 40'd50, 40'd80, VMAX - 40'd9, 1'b1, KIND_ACK);
		directed_rows[8]  = mk_row(CMD_LOAD, 40'd400, 40'd400, 40'd7, 1'b1, KIND_ACK);
		directed_rows[9]  = mk_row(CMD_LOAD, 40'd500, 40'd450, 40'd9, 1'b1, KIND_ACK);
		directed_rows[10] = mk_row(CMD_LOAD, '0, 40'd10, VMAX, 1'b1, KIND_ACK);
		directed_rows[11] = mk_row(CMD_LOAD, VMAX - 40'd100, VMAX, '0, 1'b1, KIND_ACK);
		directed_rows[12] = mk_row(CMD_LOAD, 40'd1000, 40'd2000, 40'd1000, 1'b1, KIND_ACK);
		directed_rows[13] = mk_row(CMD_LOAD, 40'd250, 40'd260, VMAX - 40'd4, 1'b1, KIND_ACK);
		directed_rows[14] = mk_row(CMD_LOAD, 40'd2000, 40'd3000, 40'd123456789, 1'b1,
			KIND_ACK);
		directed_rows[15] = mk_row(CMD_LOAD, 40'd5, 40'd7, '0, 1'b1, KIND_ACK);
		directed_rows[16] = mk_row(CMD_LOAD, 40'd4000, 40'd5000, '0, 1'b1, KIND_ACK);
		directed_rows[17] = mk_row(CMD_LOAD, 40'd6000, 40'd7000, 40'h80_0000_0000, 1'b1,
			KIND_ACK);
		directed_rows[18] = mk_row(CMD_LOAD, VMAX - 40'd1, VMAX, 40'd77, 1'b1, KIND_ACK);
		directed_rows[19] = mk_row(CMD_LOAD, 40'd10, 40'd20, 40'd30, 1'b1, KIND_ACK);
		directed_rows[20] = mk_row(CMD_LOAD, '0, VMAX, 40'd5, 1'b1, KIND_ACK);
		directed_rows[21] = mk_row(CMD_LOAD, 40'd1, 40'd2, 40'd3, 1'b1, KIND_FULL);
		directed_rows[22] = mk_row(CMD_XLATE, '0, VMAX, '0, 1'b0, KIND_ACK);
		directed_rows[23] = mk_row(CMD_XLATE, 40'd90, 40'd1500, '0, 1'b0, KIND_ACK);
		directed_rows[24] = mk_row(CMD_CLEAR, VMAX, VMAX, VMAX, 1'b1, KIND_ACK);
		foreach (directed_rows[i])
			send_word(directed_rows[i].cmd, directed_rows[i].vs, directed_rows[i].ve,
				directed_rows[i].ds, directed_rows[i].fixed, directed_rows[i].kind);

		// Random part: mostly clear, load, then several queries; some noise.
		while (words_sent < NUM_DIRECTED + NUM_RANDOM) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0:       window_base = '0;
				1:       window_base = VMAX - 40'd4095;
				default: window_base = rand_wide();
			endcase
			if ($urandom_range(0, 9) < 8) begin
				send_word(CMD_CLEAR, rand_point(), rand_point(), rand_wide(), 1'b0, KIND_ACK);
				if ($urandom_range(0, 4) == 0)
					n_entries = $urandom_range(14, MAX_ENTRIES + 2);
				else
					n_entries = $urandom_range(0, 8);
				repeat (n_entries) send_entry();
				n_queries = $urandom_range(2, 6);
				repeat (n_queries) send_query();
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(2'($urandom_range(0, 3)), rand_point(), rand_wide(),
						rand_wide(), 1'b0, KIND_ACK);
			end
		end
		req_if.valid = 1'b0;

		// Drain every due word, then watch for strays.
		while (remap_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && remap_due.size() == 0) begin
			$display("interval_range_remap_core_tb passed");
		end else begin
			$display("interval_range_remap_core_tb failed");
		end
		$finish;
	end

endmodule
